### src/ter_pkg.sv
//------------------------------------------------------------------------------
// ter_pkg
// Shared types, codes and constants of the timestamped event recorder.
//------------------------------------------------------------------------------
`default_nettype none

package ter_pkg;

	localparam int OFFSET_BITS = 12;
	localparam int TRACK_BITS  = 8;
	localparam int ADDR_W      = 20;
	localparam int TICK_W      = 24;
	localparam int BYTE_W      = 8;
	localparam int FUNC_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int STEP_W      = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_BYTE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_NEXT  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_PREV  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DONE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END       = 2'd3;

	localparam logic RK_MEM  = 1'b0;
	localparam logic RK_SEND = 1'b1;

	localparam logic [BYTE_W-1:0]      THRESHOLD_RESET = 8'h84;
	localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] OFF_FOUR = OFFSET_BITS'(4);
	localparam logic [TRACK_BITS-1:0]  TRK_ONE  = TRACK_BITS'(1);
	localparam logic [TICK_W-1:0]      TICK_ONE = TICK_W'(1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_STARTUP,
		PH_RECORD
	} phase_t;

	typedef enum logic [1:0] {
		JOB_STORE,
		JOB_SEND,
		JOB_START,
		JOB_RECORD
	} job_kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] mem_address;
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] two_byte_threshold;
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] done_code;
		logic [BYTE_W-1:0] end_code;
	} cfg_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [TRACK_BITS-1:0]  track;
		logic [OFFSET_BITS-1:0] offset;
		logic [TICK_W-1:0]      tick;
		logic [BYTE_W-1:0]      data;
	} job_t;

	function automatic logic [ADDR_W-1:0] make_addr(input logic [TRACK_BITS-1:0] track,
		input logic [OFFSET_BITS-1:0] offset);
		logic [ADDR_W+TRACK_BITS+OFFSET_BITS-1:0] wide;
		wide = {{ADDR_W{1'b0}}, track, offset};
		return wide[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/ter_front.sv
//------------------------------------------------------------------------------
// ter_front
// Accepts items, keeps the recorder state and issues jobs for the back end.
//------------------------------------------------------------------------------
`default_nettype none

module ter_front import ter_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire in_item_t  in_item,
	input  wire cfg_t      cfg,
	output logic           push,
	output job_t           job
);

	phase_t                 phase_q, phase_d;
	logic                   saw_done_q, saw_done_d;
	logic                   awaiting_q, awaiting_d;
	logic [TRACK_BITS-1:0]  track_q, track_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [TICK_W-1:0]      tick_q, tick_d;
	logic                   has_job;

	// next state
	always_comb begin
		phase_d    = phase_q;
		saw_done_d = saw_done_q;
		awaiting_d = awaiting_q;
		track_d    = track_q;
		offset_d   = offset_q;
		tick_d     = tick_q;
		case (in_item.func)
			FUNC_TICK: begin
				if (phase_q == PH_RECORD) tick_d = tick_q + TICK_ONE;
			end
			FUNC_BYTE: begin
				if (phase_q == PH_STARTUP) begin
					offset_d = offset_q + OFF_ONE;
					if (saw_done_q) begin
						saw_done_d = 1'b0;
						if (in_item.in_byte == cfg.done_code) begin
							phase_d = PH_RECORD;
							tick_d  = '0;
						end
					end else if (in_item.in_byte == cfg.done_code) begin
						saw_done_d = 1'b1;
					end
				end else if (phase_q == PH_RECORD) begin
					if (!awaiting_q) begin
						offset_d   = offset_q + OFF_FOUR;
						tick_d     = '0;
						awaiting_d = in_item.in_byte > cfg.two_byte_threshold;
					end else begin
						offset_d   = offset_q + OFF_ONE;
						awaiting_d = 1'b0;
					end
				end
			end
			FUNC_START: begin
				if (phase_q == PH_IDLE) begin
					tick_d     = '0;
					offset_d   = OFF_ONE;
					saw_done_d = 1'b0;
					phase_d    = PH_STARTUP;
				end
			end
			FUNC_STOP: begin
				if (phase_q == PH_RECORD) begin
					tick_d  = '0;
					phase_d = PH_IDLE;
				end
			end
			FUNC_NEXT: begin
				if (phase_q == PH_IDLE) begin
					track_d  = track_q + TRK_ONE;
					offset_d = '0;
				end
			end
			FUNC_PREV: begin
				if (phase_q == PH_IDLE) begin
					track_d  = track_q - TRK_ONE;
					offset_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// job issue
	always_comb begin
		has_job    = 1'b0;
		job.kind   = JOB_STORE;
		job.track  = track_q;
		job.offset = offset_q;
		job.tick   = tick_q;
		job.data   = in_item.in_byte;
		case (in_item.func)
			FUNC_BYTE: begin
				if (phase_q == PH_STARTUP) begin
					has_job = 1'b1;
				end else if (phase_q == PH_RECORD) begin
					has_job  = 1'b1;
					job.kind = awaiting_q ? JOB_STORE : JOB_RECORD;
				end
			end
			FUNC_START: begin
				if (phase_q == PH_IDLE) begin
					has_job    = 1'b1;
					job.kind   = JOB_START;
					job.offset = '0;
					job.data   = cfg.start_code;
				end
			end
			FUNC_STOP: begin
				if (phase_q == PH_RECORD) begin
					has_job  = 1'b1;
					job.kind = JOB_SEND;
					job.data = cfg.end_code;
				end
			end
			default: begin
			end
		endcase
	end

	assign push = in_fire && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			saw_done_q <= 1'b0;
			awaiting_q <= 1'b0;
			track_q    <= '0;
			offset_q   <= '0;
			tick_q     <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			saw_done_q <= saw_done_d;
			awaiting_q <= awaiting_d;
			track_q    <= track_d;
			offset_q   <= offset_d;
			tick_q     <= tick_d;
		end
	end

endmodule

`default_nettype wire

### src/ter_queue.sv
//------------------------------------------------------------------------------
// ter_queue
// Short job queue between the front end and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module ter_queue import ter_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output job_t      head
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### src/ter_back.sv
//------------------------------------------------------------------------------
// ter_back
// Expands jobs into memory writes and sent bytes, one per cycle unless stalled.
//------------------------------------------------------------------------------
`default_nettype none

module ter_back import ter_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_item
);

	logic [STEP_W-1:0]      step_q;
	logic                   out_valid_q;
	out_item_t              out_q;
	out_item_t              res;
	logic [STEP_W-1:0]      last_step;
	logic [OFFSET_BITS-1:0] offset;
	logic                   advance;

	assign offset  = head.offset + OFFSET_BITS'(step_q);
	assign advance = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		res.kind        = RK_MEM;
		res.mem_address = make_addr(head.track, offset);
		res.out_byte    = head.data;
		last_step       = '0;
		case (head.kind)
			JOB_STORE: begin
			end
			JOB_SEND: begin
				res.kind        = RK_SEND;
				res.mem_address = '0;
			end
			JOB_START: begin
				last_step = STEP_W'(1);
				if (step_q != '0) begin
					res.kind        = RK_SEND;
					res.mem_address = '0;
				end
			end
			JOB_RECORD: begin
				last_step = STEP_W'(3);
				case (step_q)
					2'd0:    res.out_byte = head.tick[23:16];
					2'd1:    res.out_byte = head.tick[15:8];
					2'd2:    res.out_byte = head.tick[7:0];
					default: res.out_byte = head.data;
				endcase
			end
			default: begin
			end
		endcase
		res.last = step_q == last_step;
	end

	assign pop       = advance && res.last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (advance) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= res.last ? '0 : step_q + STEP_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/timestamped_event_recorder.sv
//------------------------------------------------------------------------------
// timestamped_event_recorder
// Records received command bytes with tick durations into track memory.
//------------------------------------------------------------------------------
// An item is taken in every cycle while the two-entry job queue has room; the
// front end updates phase, track, offset and tick count in that same cycle.
// Results leave through one output register at one per cycle while out_ready
// is high; an item yields one result, two for a record start and four for a
// command byte in record mode (three duration bytes and the command). The back
// end's one-result-per-cycle output sets the sustained rate; items that yield
// no result push no job into the queue.
//------------------------------------------------------------------------------
`default_nettype none

module timestamped_event_recorder import ter_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata
);

	cfg_t cfg_q;
	logic in_fire;
	logic push;
	job_t push_job;
	logic full;
	logic head_valid;
	job_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_byte_threshold <= THRESHOLD_RESET;
			cfg_q.start_code         <= '0;
			cfg_q.done_code          <= '0;
			cfg_q.end_code           <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.two_byte_threshold <= cfg_wdata;
				CFG_START:     cfg_q.start_code         <= cfg_wdata;
				CFG_DONE:      cfg_q.done_code          <= cfg_wdata;
				CFG_END:       cfg_q.end_code           <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !full;
	assign in_fire  = in_valid && in_ready;

	ter_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_item (in_item),
		.cfg     (cfg_q),
		.push    (push),
		.job     (push_job)
	);

	ter_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	ter_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire
